FILE: rtl/dsol_pkg.sv
// Package for the distance sorted object list: request and status codes,
// sequencer states, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package dsol_pkg;

  // Parameter defaults
  localparam int LIST_DEPTH_DEF = 64;
  localparam int ID_WIDTH_DEF   = 16;

  // Fixed field widths
  localparam int KEY_W  = 32;
  localparam int CFG_W  = 8;
  localparam int IDX_W  = 6;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'hFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_FRAME  = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 3'd0,
    ST_BUDGET   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_LAST,
    S_REM_SCAN,
    S_READ_WAIT,
    S_RESP
  } state_t;

  // Result handoff from the sequencer to the output stage
  typedef struct packed {
    logic    push;
    status_t status;
  } res_ctl_t;

endpackage

FILE: rtl/dsol_mem.sv
// Entry memory of the sorted list: one write port, one read port,
// read data registered. Uses no package items.
`timescale 1ns / 1ps

module dsol_mem #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 48,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/dsol_ctrl.sv
// Request sequencer of the sorted list: walks the entry memory one read per
// cycle to shift entries on insert and remove, and keeps count and budget.
// Depends on dsol_pkg.
`timescale 1ns / 1ps

module dsol_ctrl #(
  parameter int LIST_DEPTH = dsol_pkg::LIST_DEPTH_DEF,
  parameter int ID_WIDTH   = dsol_pkg::ID_WIDTH_DEF,
  localparam int AW        = $clog2(LIST_DEPTH),
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
  localparam int DATA_W    = ID_WIDTH + dsol_pkg::KEY_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request side
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dsol_pkg::REQ_W-1:0]    req_type,
  input  logic [ID_WIDTH-1:0]           obj_id,
  input  logic [dsol_pkg::KEY_W-1:0]    dist_key,
  input  logic [dsol_pkg::IDX_W-1:0]    read_index,
  input  logic [dsol_pkg::CFG_W-1:0]    cfg_max,
  // result side
  input  logic                          res_free,
  output dsol_pkg::res_ctl_t            res_ctl,
  output logic [ID_WIDTH-1:0]           res_id,
  output logic [dsol_pkg::KEY_W-1:0]    res_key,
  output logic [CNT_W-1:0]              cnt,
  // memory side
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [DATA_W-1:0]             mem_rd_data,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [DATA_W-1:0]             mem_wr_data
);

  localparam int CMP_W = (CNT_W > dsol_pkg::IDX_W) ? CNT_W : dsol_pkg::IDX_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  dsol_pkg::state_t          state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [dsol_pkg::CFG_W-1:0] chg_r, chg_nxt;
  logic [AW-1:0]             dat_addr_r, dat_addr_nxt;
  logic                      found_r, found_nxt;
  logic [ID_WIDTH-1:0]       id_r, id_nxt;
  logic [dsol_pkg::KEY_W-1:0] key_r, key_nxt;
  dsol_pkg::status_t         st_r, st_nxt;
  logic [ID_WIDTH-1:0]       res_id_r, res_id_nxt;
  logic [dsol_pkg::KEY_W-1:0] res_key_r, res_key_nxt;

  logic [CNT_W-1:0]          cnt_dec;
  logic [CMP_W-1:0]          idx_ext;
  logic [CMP_W-1:0]          cnt_ext;
  logic [ID_WIDTH-1:0]       rd_id;
  logic [dsol_pkg::KEY_W-1:0] rd_key;
  logic                      last_addr;
  logic                      hit;

  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign idx_ext   = CMP_W'(read_index);
  assign cnt_ext   = CMP_W'(cnt_r);
  assign rd_id     = mem_rd_data[DATA_W-1:dsol_pkg::KEY_W];
  assign rd_key    = mem_rd_data[dsol_pkg::KEY_W-1:0];
  assign last_addr = (dat_addr_r == cnt_dec[AW-1:0]);
  assign hit       = (rd_id == id_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsol_pkg::S_IDLE;
      cnt_r   <= '0;
      chg_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chg_r   <= chg_nxt;
      found_r <= found_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    dat_addr_r <= dat_addr_nxt;
    id_r       <= id_nxt;
    key_r      <= key_nxt;
    st_r       <= st_nxt;
    res_id_r   <= res_id_nxt;
    res_key_r  <= res_key_nxt;
  end

  // next state, memory access and result
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    chg_nxt      = chg_r;
    dat_addr_nxt = dat_addr_r;
    found_nxt    = found_r;
    id_nxt       = id_r;
    key_nxt      = key_r;
    st_nxt       = st_r;
    res_id_nxt   = res_id_r;
    res_key_nxt  = res_key_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = dat_addr_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = dat_addr_r;
    mem_wr_data  = {id_r, key_r};
    in_ready     = 1'b0;
    res_ctl      = '{push: 1'b0, status: st_r};

    case (state_r)
      dsol_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          id_nxt      = obj_id;
          key_nxt     = dist_key;
          st_nxt      = dsol_pkg::ST_DONE;
          res_id_nxt  = '0;
          res_key_nxt = '0;
          found_nxt   = 1'b0;
          state_nxt   = dsol_pkg::S_RESP;
          case (req_type)
            dsol_pkg::REQ_INSERT: begin
              if (chg_r >= cfg_max) begin
                st_nxt = dsol_pkg::ST_BUDGET;
              end else if (cnt_r == DEPTH_C) begin
                st_nxt = dsol_pkg::ST_FULL;
              end else begin
                chg_nxt = chg_r + dsol_pkg::CFG_W'(1);
                if (cnt_r == '0) begin
                  // empty list: place at the head
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = '0;
                  mem_wr_data = {obj_id, dist_key};
                  cnt_nxt     = cnt_r + CNT_W'(1);
                end else begin
                  // walk down from the tail
                  mem_rd_en    = 1'b1;
                  mem_rd_addr  = cnt_dec[AW-1:0];
                  dat_addr_nxt = cnt_dec[AW-1:0];
                  state_nxt    = dsol_pkg::S_INS_SCAN;
                end
              end
            end
            dsol_pkg::REQ_REMOVE: begin
              if (cnt_r == '0) begin
                st_nxt = dsol_pkg::ST_NOTFOUND;
              end else begin
                mem_rd_en    = 1'b1;
                mem_rd_addr  = '0;
                dat_addr_nxt = '0;
                state_nxt    = dsol_pkg::S_REM_SCAN;
              end
            end
            dsol_pkg::REQ_FRAME: begin
              chg_nxt = '0;
            end
            dsol_pkg::REQ_CLEAR: begin
              cnt_nxt = '0;
            end
            dsol_pkg::REQ_READ: begin
              if (idx_ext < cnt_ext) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_ext[AW-1:0];
                state_nxt   = dsol_pkg::S_READ_WAIT;
              end else begin
                st_nxt = dsol_pkg::ST_RANGE;
              end
            end
            default: begin
              st_nxt = dsol_pkg::ST_DONE;
            end
          endcase
        end
      end

      dsol_pkg::S_INS_SCAN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = dat_addr_r + AW'(1);
        if (rd_key > key_r) begin
          // shift this entry up one place
          mem_wr_data = mem_rd_data;
          if (dat_addr_r == '0) begin
            state_nxt = dsol_pkg::S_INS_LAST;
          end else begin
            mem_rd_en    = 1'b1;
            mem_rd_addr  = dat_addr_r - AW'(1);
            dat_addr_nxt = dat_addr_r - AW'(1);
          end
        end else begin
          // new entry lands just above this one
          mem_wr_data = {id_r, key_r};
          cnt_nxt     = cnt_r + CNT_W'(1);
          state_nxt   = dsol_pkg::S_RESP;
        end
      end

      dsol_pkg::S_INS_LAST: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = '0;
        mem_wr_data = {id_r, key_r};
        cnt_nxt     = cnt_r + CNT_W'(1);
        state_nxt   = dsol_pkg::S_RESP;
      end

      dsol_pkg::S_REM_SCAN: begin
        // after the match, move each later entry down one place
        if (found_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = dat_addr_r - AW'(1);
          mem_wr_data = mem_rd_data;
        end else if (hit) begin
          found_nxt = 1'b1;
        end
        if (last_addr) begin
          if (found_r || hit) begin
            cnt_nxt = cnt_dec;
          end else begin
            st_nxt = dsol_pkg::ST_NOTFOUND;
          end
          state_nxt = dsol_pkg::S_RESP;
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = dat_addr_r + AW'(1);
          dat_addr_nxt = dat_addr_r + AW'(1);
        end
      end

      dsol_pkg::S_READ_WAIT: begin
        res_id_nxt  = rd_id;
        res_key_nxt = rd_key;
        state_nxt   = dsol_pkg::S_RESP;
      end

      dsol_pkg::S_RESP: begin
        // hold until the output stage has room
        res_ctl.push = res_free;
        if (res_free) begin
          state_nxt = dsol_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dsol_pkg::S_IDLE;
      end
    endcase
  end

  assign res_id  = res_id_r;
  assign res_key = res_key_r;
  assign cnt     = cnt_r;

endmodule

FILE: rtl/distance_sorted_object_list_core.sv
// Channel    | Direction | Handshake              | Carries
// in_        | in        | in_valid / in_ready    | req_type, obj_id, dist_key, read_index
// out_       | out       | out_valid / out_ready  | status, entry_id, entry_key, entry_count
// cfg_       | in        | cfg_valid / cfg_ready  | max_changes_per_frame
//
// Insert walks down from the tail and remove scans from the head, reading
// the entry memory once per cycle while entries are scanned or shifted. Read
// waits for registered data; new frame, clear, unknown requests go straight to the result.
// No clearing pass after reset: the live count bounds every memory read.
// A stalled result holds in the output register; the block takes one more
// request meanwhile and waits at its result until the register frees.
//
// Top level of the distance sorted object list. Depends on dsol_pkg,
// dsol_mem and dsol_ctrl.
`timescale 1ns / 1ps

module distance_sorted_object_list_core #(
  parameter int LIST_DEPTH = dsol_pkg::LIST_DEPTH_DEF,
  parameter int ID_WIDTH   = dsol_pkg::ID_WIDTH_DEF,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dsol_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ID_WIDTH-1:0]           in_obj_id,
  input  logic [dsol_pkg::KEY_W-1:0]    in_dist_key,
  input  logic [dsol_pkg::IDX_W-1:0]    in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsol_pkg::STAT_W-1:0]   out_status,
  output logic [ID_WIDTH-1:0]           out_entry_id,
  output logic [dsol_pkg::KEY_W-1:0]    out_entry_key,
  output logic [CNT_W-1:0]              out_entry_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsol_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW     = $clog2(LIST_DEPTH);
  localparam int DATA_W = ID_WIDTH + dsol_pkg::KEY_W;

  logic [dsol_pkg::CFG_W-1:0]  cfg_max_r;
  logic                        out_valid_r;
  dsol_pkg::status_t           out_status_r;
  logic [ID_WIDTH-1:0]         out_id_r;
  logic [dsol_pkg::KEY_W-1:0]  out_key_r;
  logic [CNT_W-1:0]            out_cnt_r;

  logic                        res_free;
  dsol_pkg::res_ctl_t          res_ctl;
  logic [ID_WIDTH-1:0]         res_id;
  logic [dsol_pkg::KEY_W-1:0]  res_key;
  logic [CNT_W-1:0]            cnt;
  logic                        mem_rd_en;
  logic [AW-1:0]               mem_rd_addr;
  logic [DATA_W-1:0]           mem_rd_data;
  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  logic [DATA_W-1:0]           mem_wr_data;

  // budget register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_r <= dsol_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      cfg_max_r <= cfg_data;
    end
  end

  dsol_mem #(
    .DEPTH  (LIST_DEPTH),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  dsol_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (in_req_type),
    .obj_id      (in_obj_id),
    .dist_key    (in_dist_key),
    .read_index  (in_read_index),
    .cfg_max     (cfg_max_r),
    .res_free    (res_free),
    .res_ctl     (res_ctl),
    .res_id      (res_id),
    .res_key     (res_key),
    .cnt         (cnt),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // output register: free when empty or being taken
  assign res_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ctl.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ctl.push) begin
      out_status_r <= res_ctl.status;
      out_id_r     <= res_id;
      out_key_r    <= res_key;
      out_cnt_r    <= cnt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_id    = out_id_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_count = out_cnt_r;

endmodule

FILE: rtl/dsol_checker.sv
// Port checker for the distance sorted object list, bound to the top level.
// Depends on dsol_pkg and distance_sorted_object_list_core.
`timescale 1ns / 1ps

module dsol_checker #(
  parameter int LIST_DEPTH = dsol_pkg::LIST_DEPTH_DEF,
  parameter int ID_WIDTH   = dsol_pkg::ID_WIDTH_DEF,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dsol_pkg::STAT_W-1:0]   out_status,
  input logic [ID_WIDTH-1:0]           out_entry_id,
  input logic [dsol_pkg::KEY_W-1:0]    out_entry_key,
  input logic [CNT_W-1:0]              out_entry_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_entry_count))
    else $error("result changed while stalled");

  // count never exceeds the list depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= dsol_pkg::ST_RANGE)
    else $error("undefined status code");

  // failed read returns zero payload
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dsol_pkg::ST_RANGE |->
      out_entry_id == '0 && out_entry_key == '0)
    else $error("out of range read carries data");

  // full list only reported when the list is at depth
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dsol_pkg::ST_FULL |->
      out_entry_count == CNT_W'(LIST_DEPTH))
    else $error("full status below depth");

endmodule

bind distance_sorted_object_list_core dsol_checker #(
  .LIST_DEPTH (LIST_DEPTH),
  .ID_WIDTH   (ID_WIDTH)
) u_dsol_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_entry_id    (out_entry_id),
  .out_entry_key   (out_entry_key),
  .out_entry_count (out_entry_count)
);
